FILE: sv/hcr_pkg.sv
package hcr_pkg;

    // Frame limits and the widths that follow from them.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 12;
    localparam int POS_W      = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int EXT_W      = (POS_W + 1 > DIM_W) ? POS_W + 1 : DIM_W;
    localparam int MIN_DIM    = 3;

    // Field widths.
    localparam int PIX_W     = 8;
    localparam int K_W       = 16;
    localparam int CFG_W     = 16;
    localparam int GRAD_W    = 11;
    localparam int GPAIR_W   = 2 * GRAD_W;
    localparam int COORD_W   = 11;
    localparam int RESP_W    = 47;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_K      = 2'd2;

    // Sobel column slots.
    localparam logic [1:0] COL_LEFT  = 2'd0;
    localparam logic [1:0] COL_MID   = 2'd1;
    localparam logic [1:0] COL_RIGHT = 2'd2;

    // Result jobs of one pixel, in emission order.
    localparam logic [1:0] JOB_UPPER_PREV = 2'd0;
    localparam logic [1:0] JOB_UPPER_EDGE = 2'd1;
    localparam logic [1:0] JOB_LAST_PREV  = 2'd2;
    localparam logic [1:0] JOB_LAST_EDGE  = 2'd3;

    typedef struct packed {
        logic       load;
        logic       pix_we;
        logic       pix_rd;
        logic [1:0] col_sel;
        logic       sec;
        logic       g_load;
        logic       grd_rd;
        logic       grd_slot;
        logic       g_we;
        logic       h_start;
        logic       out_load;
        logic       last;
        logic       advance;
        logic [1:0] job;
    } hcr_cmd_t;

    typedef struct packed {
        logic [3:0] jobs;
        logic       c_nonzero;
        logic       h_done;
        logic       out_free;
    } hcr_status_t;

    // True for the jobs that produce a response on the last row.
    function automatic logic job_is_last(input logic [1:0] job);
        return (job == JOB_LAST_PREV) || (job == JOB_LAST_EDGE);
    endfunction

endpackage

FILE: sv/hcr_harris.sv
module hcr_harris (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [hcr_pkg::K_W-1:0]                   k,
    input  logic [3:0][hcr_pkg::GPAIR_W-1:0]          g,
    output logic                                      done,
    output logic [hcr_pkg::RESP_W-1:0]                result
);

    localparam int MW = 25;
    localparam int PW = 2 * MW;

    logic signed [hcr_pkg::GRAD_W-1:0] gx_reg [4];
    logic signed [hcr_pkg::GRAD_W-1:0] gy_reg [4];
    logic                              busy_reg;
    logic                              done_reg;
    logic [4:0]                        step_reg;
    logic signed [PW-1:0]              p_reg;
    logic signed [23:0]                sxx_reg;
    logic signed [23:0]                syy_reg;
    logic signed [23:0]                sxy_reg;
    logic signed [47:0]                det_reg;
    logic [45:0]                       tr2_reg;
    logic [39:0]                       ktlo_reg;
    logic [62:0]                       kt_reg;
    logic [hcr_pkg::RESP_W-1:0]        res_reg;

    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [MW-1:0] trace;
    logic signed [47:0]   res_full;
    logic [1:0]           lane;

    assign lane  = step_reg[1:0];
    assign trace = {sxx_reg[23], sxx_reg} + {syy_reg[23], syy_reg};

    // Operand selection for the shared multiplier, one product per step.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (step_reg < 5'd4)
        begin
            mul_a = {{(MW-hcr_pkg::GRAD_W){gx_reg[lane][hcr_pkg::GRAD_W-1]}}, gx_reg[lane]};
            mul_b = mul_a;
        end
        else if (step_reg < 5'd8)
        begin
            mul_a = {{(MW-hcr_pkg::GRAD_W){gy_reg[lane][hcr_pkg::GRAD_W-1]}}, gy_reg[lane]};
            mul_b = mul_a;
        end
        else if (step_reg < 5'd12)
        begin
            mul_a = {{(MW-hcr_pkg::GRAD_W){gx_reg[lane][hcr_pkg::GRAD_W-1]}}, gx_reg[lane]};
            mul_b = {{(MW-hcr_pkg::GRAD_W){gy_reg[lane][hcr_pkg::GRAD_W-1]}}, gy_reg[lane]};
        end
        else if (step_reg == 5'd12)
        begin
            mul_a = {sxx_reg[23], sxx_reg};
            mul_b = {syy_reg[23], syy_reg};
        end
        else if (step_reg == 5'd13)
        begin
            mul_a = {sxy_reg[23], sxy_reg};
            mul_b = {sxy_reg[23], sxy_reg};
        end
        else if (step_reg == 5'd14)
        begin
            mul_a = trace;
            mul_b = trace;
        end
        else if (step_reg == 5'd15)
        begin
            mul_a = {9'd0, k};
            mul_b = {2'd0, p_reg[22:0]};
        end
        else if (step_reg == 5'd16)
        begin
            mul_a = {9'd0, k};
            mul_b = {2'd0, tr2_reg[45:23]};
        end
    end

    assign res_full = det_reg - {1'b0, kt_reg[62:16]};

    // Step sequence: products are registered and folded in one step later.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 5'd1;
            if (step_reg == 5'd18)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < 4; i++)
            begin
                gx_reg[i] <= g[i][hcr_pkg::GPAIR_W-1:hcr_pkg::GRAD_W];
                gy_reg[i] <= g[i][hcr_pkg::GRAD_W-1:0];
            end
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
        end
        else if (busy_reg)
        begin
            p_reg <= mul_a * mul_b;
            if (step_reg >= 5'd1 && step_reg <= 5'd4)
            begin
                sxx_reg <= sxx_reg + p_reg[23:0];
            end
            else if (step_reg >= 5'd5 && step_reg <= 5'd8)
            begin
                syy_reg <= syy_reg + p_reg[23:0];
            end
            else if (step_reg >= 5'd9 && step_reg <= 5'd12)
            begin
                sxy_reg <= sxy_reg + p_reg[23:0];
            end
            else if (step_reg == 5'd13)
            begin
                det_reg <= p_reg[47:0];
            end
            else if (step_reg == 5'd14)
            begin
                det_reg <= det_reg - p_reg[47:0];
            end
            else if (step_reg == 5'd15)
            begin
                tr2_reg <= p_reg[45:0];
            end
            else if (step_reg == 5'd16)
            begin
                ktlo_reg <= p_reg[39:0];
            end
            else if (step_reg == 5'd17)
            begin
                kt_reg <= {p_reg[39:0], 23'd0} + {23'd0, ktlo_reg};
            end
            else if (step_reg == 5'd18)
            begin
                res_reg <= res_full[hcr_pkg::RESP_W-1:0];
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

FILE: sv/hcr_datapath.sv
module hcr_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [hcr_pkg::CFG_W-1:0]     cfg_data,
    input  logic [hcr_pkg::PIX_W-1:0]     pixel,
    input  hcr_pkg::hcr_cmd_t             cmd,
    output hcr_pkg::hcr_status_t          status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hcr_pkg::COORD_W-1:0]   out_row,
    output logic [hcr_pkg::COORD_W-1:0]   out_col,
    output logic [hcr_pkg::RESP_W-1:0]    response,
    output logic                          last_of_run
);

    localparam int CW = hcr_pkg::COL_W;
    localparam int RW = hcr_pkg::ROW_W;
    localparam int EW = hcr_pkg::EXT_W;
    localparam int PXW = hcr_pkg::PIX_W;
    localparam int GW = hcr_pkg::GPAIR_W;

    // Configuration registers.
    logic [hcr_pkg::DIM_W-1:0] width_reg;
    logic [hcr_pkg::DIM_W-1:0] height_reg;
    logic [hcr_pkg::K_W-1:0]   k_reg;

    // Position and line rotation.
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [1:0]    cur_bank_reg;
    logic          gbank_reg;
    logic [PXW-1:0] pix_reg;

    // Line stores.
    logic [PXW-1:0] pmem0 [hcr_pkg::MAX_WIDTH];
    logic [PXW-1:0] pmem1 [hcr_pkg::MAX_WIDTH];
    logic [PXW-1:0] pmem2 [hcr_pkg::MAX_WIDTH];
    logic [GW-1:0]  gmem0 [hcr_pkg::MAX_WIDTH];
    logic [GW-1:0]  gmem1 [hcr_pkg::MAX_WIDTH];
    logic [PXW-1:0] prd_reg [3];
    logic [GW-1:0]  grd0_reg;
    logic [GW-1:0]  grd1_reg;

    // Capture control, registered from the read commands in step with the read data.
    logic       pcap_reg;
    logic [1:0] pslot_reg;
    logic       gcap_reg;
    logic       gslot_reg;

    logic [PXW-1:0] win_reg [3][3];
    logic [GW-1:0]  g3_reg;
    logic [GW-1:0]  g2_reg;
    logic [GW-1:0]  prev_cm1_reg;
    logic [GW-1:0]  cur_cm1_reg;
    logic [GW-1:0]  prev_c_reg;
    logic [GW-1:0]  cur_c_reg;

    // Output register.
    logic                        out_valid_reg;
    logic [hcr_pkg::COORD_W-1:0] out_row_reg;
    logic [hcr_pkg::COORD_W-1:0] out_col_reg;
    logic [hcr_pkg::RESP_W-1:0]  resp_reg;
    logic                        last_reg;

    logic [EW-1:0] w_eff;
    logic [EW-1:0] h_eff;
    logic [EW-1:0] w_cfg;
    logic [EW-1:0] h_cfg;
    logic          is_last;
    logic [CW-1:0] col_c;
    logic [CW-1:0] cs_col;
    logic [CW-1:0] col_left;
    logic [CW-1:0] col_right;
    logic [CW-1:0] pix_addr;
    logic [CW-1:0] grd_addr;
    logic [1:0]    upper_bank;
    logic [1:0]    lower_bank;
    logic [1:0]    a_bank;
    logic [1:0]    m_bank;
    logic [1:0]    b_bank;
    logic          c_nz;
    logic          y_ge2;
    logic [9:0]    s_right;
    logic [9:0]    s_left;
    logic [9:0]    s_below;
    logic [9:0]    s_above;
    logic signed [hcr_pkg::GRAD_W-1:0] gx_new;
    logic signed [hcr_pkg::GRAD_W-1:0] gy_new;
    logic [GW-1:0] cur_rd;
    logic [GW-1:0] prev_rd;
    logic [3:0][GW-1:0] hg;
    logic          h_done;
    logic [hcr_pkg::RESP_W-1:0] h_result;

    // Clamped geometry.
    assign w_cfg = EW'(width_reg);
    assign h_cfg = EW'(height_reg);

    always_comb
    begin
        priority if (w_cfg < EW'(hcr_pkg::MIN_DIM))
            w_eff = EW'(hcr_pkg::MIN_DIM);
        else if (w_cfg > EW'(hcr_pkg::MAX_WIDTH))
            w_eff = EW'(hcr_pkg::MAX_WIDTH);
        else
            w_eff = w_cfg;
        priority if (h_cfg < EW'(hcr_pkg::MIN_DIM))
            h_eff = EW'(hcr_pkg::MIN_DIM);
        else if (h_cfg > EW'(hcr_pkg::MAX_HEIGHT))
            h_eff = EW'(hcr_pkg::MAX_HEIGHT);
        else
            h_eff = h_cfg;
    end

    // Column of the current job and of the Sobel pass.
    assign is_last = hcr_pkg::job_is_last(cmd.job);
    assign col_c   = (cmd.job == hcr_pkg::JOB_UPPER_EDGE || cmd.job == hcr_pkg::JOB_LAST_EDGE)
                     ? col_reg : col_reg - CW'(1);
    assign c_nz    = (col_c != '0);
    assign y_ge2   = (row_reg >= RW'(2));
    assign cs_col  = cmd.sec ? col_c - CW'(1) : col_c;

    // Reflect-101 neighbors.
    assign col_left  = (cs_col == '0) ? CW'(1) : cs_col - CW'(1);
    assign col_right = ((EW'(cs_col) + EW'(1)) >= w_eff) ? CW'(w_eff - EW'(2))
                                                          : cs_col + CW'(1);

    always_comb
    begin
        unique case (cmd.col_sel)
            hcr_pkg::COL_LEFT:  pix_addr = col_left;
            hcr_pkg::COL_MID:   pix_addr = cs_col;
            hcr_pkg::COL_RIGHT: pix_addr = col_right;
            default:            pix_addr = cs_col;
        endcase
    end

    assign grd_addr = cmd.grd_slot ? col_c : col_c - CW'(1);

    // Line roles: the upper line is the oldest bank, the lower line the one before current.
    assign upper_bank = (cur_bank_reg == 2'd2) ? 2'd0 : cur_bank_reg + 2'd1;
    assign lower_bank = (cur_bank_reg == 2'd0) ? 2'd2 : cur_bank_reg - 2'd1;
    assign a_bank = is_last ? lower_bank : ((row_reg == RW'(1)) ? cur_bank_reg : upper_bank);
    assign m_bank = is_last ? cur_bank_reg : lower_bank;
    assign b_bank = is_last ? lower_bank : cur_bank_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= hcr_pkg::DIM_W'(640);
            height_reg <= hcr_pkg::DIM_W'(480);
            k_reg      <= hcr_pkg::K_W'(2621);
        end
        else if (cfg_we)
        begin
            if (cfg_index == hcr_pkg::CFG_WIDTH)
                width_reg <= cfg_data[hcr_pkg::DIM_W-1:0];
            else if (cfg_index == hcr_pkg::CFG_HEIGHT)
                height_reg <= cfg_data[hcr_pkg::DIM_W-1:0];
            else if (cfg_index == hcr_pkg::CFG_K)
                k_reg <= cfg_data[hcr_pkg::K_W-1:0];
        end
    end

    // Position, wrap on load, advance and line rotation at row end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            cur_bank_reg <= 2'd0;
            gbank_reg    <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (EW'(col_reg) >= w_eff || EW'(row_reg) >= h_eff)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
        end
        else if (cmd.advance)
        begin
            if (EW'(col_reg) + EW'(1) >= w_eff)
            begin
                col_reg      <= '0;
                cur_bank_reg <= upper_bank;
                gbank_reg    <= ~gbank_reg;
                if (EW'(row_reg) + EW'(1) >= h_eff)
                    row_reg <= '0;
                else
                    row_reg <= row_reg + RW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            pix_reg <= pixel;
    end

    // Pixel line stores: one write into the current line, one read of all three.
    always_ff @(posedge clk)
    begin
        if (cmd.pix_we && cur_bank_reg == 2'd0)
            pmem0[col_reg] <= pix_reg;
        if (cmd.pix_we && cur_bank_reg == 2'd1)
            pmem1[col_reg] <= pix_reg;
        if (cmd.pix_we && cur_bank_reg == 2'd2)
            pmem2[col_reg] <= pix_reg;
        if (cmd.pix_rd)
        begin
            prd_reg[0] <= pmem0[pix_addr];
            prd_reg[1] <= pmem1[pix_addr];
            prd_reg[2] <= pmem2[pix_addr];
        end
    end

    // Gradient line stores.
    always_ff @(posedge clk)
    begin
        if (cmd.g_we && !gbank_reg)
            gmem0[col_c] <= g3_reg;
        if (cmd.g_we && gbank_reg)
            gmem1[col_c] <= g3_reg;
        if (cmd.grd_rd)
        begin
            grd0_reg <= gmem0[grd_addr];
            grd1_reg <= gmem1[grd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcap_reg  <= 1'b0;
            pslot_reg <= 2'd0;
            gcap_reg  <= 1'b0;
            gslot_reg <= 1'b0;
        end
        else
        begin
            pcap_reg  <= cmd.pix_rd;
            pslot_reg <= cmd.col_sel;
            gcap_reg  <= cmd.grd_rd;
            gslot_reg <= cmd.grd_slot;
        end
    end

    // Sobel window: rows a, m, b by columns left, mid, right.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
                for (int s = 0; s < 3; s++)
                    win_reg[r][s] <= '0;
        end
        else if (pcap_reg)
        begin
            win_reg[0][pslot_reg] <= prd_reg[a_bank];
            win_reg[1][pslot_reg] <= prd_reg[m_bank];
            win_reg[2][pslot_reg] <= prd_reg[b_bank];
        end
    end

    assign s_right = 10'(win_reg[0][2]) + {1'b0, win_reg[1][2], 1'b0} + 10'(win_reg[2][2]);
    assign s_left  = 10'(win_reg[0][0]) + {1'b0, win_reg[1][0], 1'b0} + 10'(win_reg[2][0]);
    assign s_below = 10'(win_reg[2][0]) + {1'b0, win_reg[2][1], 1'b0} + 10'(win_reg[2][2]);
    assign s_above = 10'(win_reg[0][0]) + {1'b0, win_reg[0][1], 1'b0} + 10'(win_reg[0][2]);
    assign gx_new  = $signed({1'b0, s_right}) - $signed({1'b0, s_left});
    assign gy_new  = $signed({1'b0, s_below}) - $signed({1'b0, s_above});

    always_ff @(posedge clk)
    begin
        if (cmd.g_load && cmd.sec)
            g2_reg <= {gx_new, gy_new};
        if (cmd.g_load && !cmd.sec)
            g3_reg <= {gx_new, gy_new};
    end

    // Gradient reads: slot zero is column c-1, slot one is column c.
    assign cur_rd  = gbank_reg ? grd1_reg : grd0_reg;
    assign prev_rd = gbank_reg ? grd0_reg : grd1_reg;

    always_ff @(posedge clk)
    begin
        if (gcap_reg && !gslot_reg)
        begin
            cur_cm1_reg  <= cur_rd;
            prev_cm1_reg <= prev_rd;
        end
        if (gcap_reg && gslot_reg)
        begin
            cur_c_reg  <= cur_rd;
            prev_c_reg <= prev_rd;
        end
    end

    // 2x2 block of gradients, zero outside the image.
    always_comb
    begin
        hg[3] = g3_reg;
        if (is_last)
        begin
            hg[0] = c_nz ? cur_cm1_reg : '0;
            hg[1] = cur_c_reg;
            hg[2] = c_nz ? g2_reg : '0;
        end
        else
        begin
            hg[0] = (y_ge2 && c_nz) ? prev_cm1_reg : '0;
            hg[1] = y_ge2 ? prev_c_reg : '0;
            hg[2] = c_nz ? cur_cm1_reg : '0;
        end
    end

    hcr_harris u_harris (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.h_start),
        .k      (k_reg),
        .g      (hg),
        .done   (h_done),
        .result (h_result)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_row_reg <= is_last ? hcr_pkg::COORD_W'(row_reg)
                                   : hcr_pkg::COORD_W'(row_reg - RW'(1));
            out_col_reg <= hcr_pkg::COORD_W'(col_c);
            resp_reg    <= h_result;
            last_reg    <= cmd.last;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        status.jobs[hcr_pkg::JOB_UPPER_PREV] = (row_reg != '0) && (col_reg != '0);
        status.jobs[hcr_pkg::JOB_UPPER_EDGE] = (row_reg != '0)
                                               && (EW'(col_reg) == w_eff - EW'(1));
        status.jobs[hcr_pkg::JOB_LAST_PREV]  = (EW'(row_reg) == h_eff - EW'(1))
                                               && (col_reg != '0);
        status.jobs[hcr_pkg::JOB_LAST_EDGE]  = (EW'(row_reg) == h_eff - EW'(1))
                                               && (EW'(col_reg) == w_eff - EW'(1));
        status.c_nonzero = c_nz;
        status.h_done    = h_done;
        status.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign response    = resp_reg;
    assign last_of_run = last_reg;

endmodule

FILE: sv/hcr_ctrl.sv
module hcr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hcr_pkg::hcr_status_t status,
    output hcr_pkg::hcr_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WRPIX  = 4'd1;
    localparam logic [3:0] S_PICK   = 4'd2;
    localparam logic [3:0] S_SRD0   = 4'd3;
    localparam logic [3:0] S_SRD1   = 4'd4;
    localparam logic [3:0] S_SRD2   = 4'd5;
    localparam logic [3:0] S_SRD3   = 4'd6;
    localparam logic [3:0] S_SGRAD  = 4'd7;
    localparam logic [3:0] S_GRD0   = 4'd8;
    localparam logic [3:0] S_GRD1   = 4'd9;
    localparam logic [3:0] S_GRD2   = 4'd10;
    localparam logic [3:0] S_HSTART = 4'd11;
    localparam logic [3:0] S_HWAIT  = 4'd12;
    localparam logic [3:0] S_EMIT   = 4'd13;
    localparam logic [3:0] S_ADV    = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic [1:0] job_reg;
    logic [1:0] job_next;
    logic       sec_reg;
    logic       sec_next;
    logic [1:0] first_job;
    logic [3:0] remaining;

    // Lowest pending job goes first, which keeps raster order.
    always_comb
    begin
        priority if (pending_reg[0])
            first_job = hcr_pkg::JOB_UPPER_PREV;
        else if (pending_reg[1])
            first_job = hcr_pkg::JOB_UPPER_EDGE;
        else if (pending_reg[2])
            first_job = hcr_pkg::JOB_LAST_PREV;
        else
            first_job = hcr_pkg::JOB_LAST_EDGE;
    end

    assign remaining = pending_reg & ~(4'b0001 << job_reg);

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        job_next     = job_reg;
        sec_next     = sec_reg;
        cmd          = '0;
        cmd.job      = job_reg;
        cmd.sec      = sec_reg;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_WRPIX;
                end
            end
            S_WRPIX:
            begin
                cmd.pix_we   = 1'b1;
                pending_next = status.jobs;
                state_next   = S_PICK;
            end
            S_PICK:
            begin
                if (pending_reg == 4'd0)
                begin
                    state_next = S_ADV;
                end
                else
                begin
                    job_next   = first_job;
                    sec_next   = 1'b0;
                    state_next = S_SRD0;
                end
            end
            S_SRD0:
            begin
                cmd.pix_rd  = 1'b1;
                cmd.col_sel = hcr_pkg::COL_LEFT;
                state_next  = S_SRD1;
            end
            S_SRD1:
            begin
                cmd.pix_rd  = 1'b1;
                cmd.col_sel = hcr_pkg::COL_MID;
                state_next  = S_SRD2;
            end
            S_SRD2:
            begin
                cmd.pix_rd  = 1'b1;
                cmd.col_sel = hcr_pkg::COL_RIGHT;
                state_next  = S_SRD3;
            end
            S_SRD3:
            begin
                state_next = S_SGRAD;
            end
            S_SGRAD:
            begin
                cmd.g_load = 1'b1;
                // Last-row jobs also need the gradient one column to the left.
                if (hcr_pkg::job_is_last(job_reg) && !sec_reg && status.c_nonzero)
                begin
                    sec_next   = 1'b1;
                    state_next = S_SRD0;
                end
                else
                begin
                    state_next = S_GRD0;
                end
            end
            S_GRD0:
            begin
                cmd.grd_rd   = 1'b1;
                cmd.grd_slot = 1'b0;
                state_next   = S_GRD1;
            end
            S_GRD1:
            begin
                cmd.grd_rd   = 1'b1;
                cmd.grd_slot = 1'b1;
                state_next   = S_GRD2;
            end
            S_GRD2:
            begin
                cmd.g_we   = !hcr_pkg::job_is_last(job_reg);
                state_next = S_HSTART;
            end
            S_HSTART:
            begin
                cmd.h_start = 1'b1;
                state_next  = S_HWAIT;
            end
            S_HWAIT:
            begin
                if (status.h_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.last     = (remaining == 4'd0);
                    pending_next = remaining;
                    state_next   = S_PICK;
                end
            end
            S_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pending_reg <= 4'd0;
            job_reg     <= hcr_pkg::JOB_UPPER_PREV;
            sec_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            job_reg     <= job_next;
            sec_reg     <= sec_next;
        end
    end

endmodule

FILE: sv/harris_corner_response_unit.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   pixel
// out       output     out_valid / out_ready out_row, out_col, response, last_of_run
// cfg       input      cfg_we                cfg_index, cfg_data
//
// One pixel item at a time; a last-row response right of column zero needs a
// second Sobel pass. The shared multiplier of the response unit sets most of the
// time taken per response.
// Reset clears position and line rotation and loads default configuration; line stores are not cleared.
// A waiting result in the output register stalls the next response only, so the
// next pixel item is taken while the last result of a pixel is still held.
module harris_corner_response_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [hcr_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hcr_pkg::PIX_W-1:0]     pixel,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hcr_pkg::COORD_W-1:0]   out_row,
    output logic [hcr_pkg::COORD_W-1:0]   out_col,
    output logic [hcr_pkg::RESP_W-1:0]    response,
    output logic                          last_of_run
);

    hcr_pkg::hcr_cmd_t    cmd;
    hcr_pkg::hcr_status_t status;

    hcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    hcr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel       (pixel),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_row     (out_row),
        .out_col     (out_col),
        .response    (response),
        .last_of_run (last_of_run)
    );

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("result loaded over a waiting result");

    // Only one pixel item is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item accepted while busy");

    // Starting the response unit withdraws its done flag.
    a_start_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.h_start |=> !status.h_done)
        else $error("response unit done flag stale after start");

endmodule
